// File: rtl/sdf_texel_coverage_core_macros.svh
// Assertion helpers shared by the coverage core files.
`ifndef SDF_TEXEL_COVERAGE_CORE_MACROS_SVH
`define SDF_TEXEL_COVERAGE_CORE_MACROS_SVH

`ifndef SYNTH

`define SDF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define SDF_ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`else

`define SDF_ASSERT(label, prop, msg)

`define SDF_ASSERT_NEXT(label, cond, conseq, msg)

`endif

`endif

// File: rtl/sdf_tc_pkg.sv
`default_nettype none

package sdf_tc_pkg;

	localparam int FRACTION_BITS_DEF = 8;

	localparam int TEXEL_W = 8;
	localparam int SCALE_W = 16;
	localparam int BIAS_W  = 10;
	localparam int KIND_W  = 2;
	localparam int ALPHA_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int N_W = 27;

	localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BIAS    = 2'd1;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam logic [BIAS_W-1:0]  BIAS_RESET  = 10'd0;

	localparam logic [KIND_W-1:0] KIND_LEAVE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BLEND = 2'd2;

	localparam logic signed [N_W-1:0] COVER_FULL_N = 27'sd130560;
	localparam logic signed [N_W-1:0] COVER_HALF_N = 27'sd65280;

endpackage

`default_nettype wire

// File: rtl/sdf_tc_bilerp.sv
`default_nettype none

`include "sdf_texel_coverage_core_macros.svh"

module sdf_tc_bilerp
	import sdf_tc_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [TEXEL_W-1:0] tl,
	input  wire logic [TEXEL_W-1:0] tr,
	input  wire logic [TEXEL_W-1:0] bl,
	input  wire logic [TEXEL_W-1:0] br,
	input  wire logic [TEXEL_W-1:0] fx_raw,
	input  wire logic [TEXEL_W-1:0] fy_raw,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [TEXEL_W-1:0]      distance
);

	localparam int FB = FRACTION_BITS;
	localparam int RW = FB + 10;
	localparam int MW = RW + FB + 2;
	localparam int HW = MW - 2 * FB;
	localparam logic [MW-1:0] RND_HALF = {{(MW - 2 * FB){1'b0}}, 1'b1, {(2 * FB - 1){1'b0}}};

	logic [FB-1:0] fx;
	logic [FB-1:0] fy;
	logic signed [8:0] dx_top;
	logic signed [8:0] dx_bot;
	logic signed [RW-1:0] top_c;
	logic signed [RW-1:0] bot_c;
	logic signed [RW:0] dy_c;
	logic signed [MW-1:0] mix_c;
	logic [MW-1:0] rnd_c;
	logic [HW-1:0] hi_c;
	logic [TEXEL_W-1:0] dist_c;

	logic v1_s1, v2_s2, v3_s3;
	logic rdy1, rdy2, rdy3;
	logic signed [RW-1:0] top_s1;
	logic signed [RW-1:0] bot_s1;
	logic [FB-1:0] fy_s1;
	logic signed [MW-1:0] mix_s2;
	logic [TEXEL_W-1:0] dist_s3;

	assign rdy3 = !v3_s3 || out_ready;
	assign rdy2 = !v2_s2 || rdy3;
	assign rdy1 = !v1_s1 || rdy2;
	assign in_ready = rdy1;

	assign fx = FB'(fx_raw);
	assign fy = FB'(fy_raw);

	always_comb begin
		dx_top = $signed({1'b0, tr}) - $signed({1'b0, tl});
		dx_bot = $signed({1'b0, br}) - $signed({1'b0, bl});
		top_c = $signed({2'b00, tl, {FB{1'b0}}}) + RW'(dx_top * $signed({1'b0, fx}));
		bot_c = $signed({2'b00, bl, {FB{1'b0}}}) + RW'(dx_bot * $signed({1'b0, fx}));
	end

	always_comb begin
		dy_c = $signed({bot_s1[RW-1], bot_s1}) - $signed({top_s1[RW-1], top_s1});
		mix_c = $signed({{2{top_s1[RW-1]}}, top_s1, {FB{1'b0}}})
			+ MW'(dy_c * $signed({1'b0, fy_s1}));
	end

	always_comb begin
		rnd_c = mix_s2[MW-1] ? RND_HALF : (MW'(mix_s2) + RND_HALF);
		hi_c = rnd_c[MW-1:2*FB];
		dist_c = (hi_c > HW'(255)) ? 8'd255 : hi_c[TEXEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			top_s1 <= top_c;
			bot_s1 <= bot_c;
			fy_s1  <= fy;
		end
		if (rdy2) mix_s2 <= mix_c;
		if (rdy3) dist_s3 <= dist_c;
	end

	assign out_valid = v3_s3;
	assign distance = dist_s3;

	`SDF_ASSERT(a_mix_nonneg, !v2_s2 || !mix_s2[MW-1], "bilinear mix went negative")
	`SDF_ASSERT_NEXT(a_s1_hold, v1_s1 && !rdy2, v1_s1 && $stable(top_s1), "stage 1 lost on stall")
	`SDF_ASSERT_NEXT(a_s2_hold, v2_s2 && !rdy3, v2_s2 && $stable(mix_s2), "stage 2 lost on stall")

endmodule

`default_nettype wire

// File: rtl/sdf_tc_cover_map.sv
`default_nettype none

`include "sdf_texel_coverage_core_macros.svh"

module sdf_tc_cover_map
	import sdf_tc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [SCALE_W-1:0] scale,
	input  wire logic [BIAS_W-1:0]  bias,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [TEXEL_W-1:0] distance,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [KIND_W-1:0]       kind,
	output logic [ALPHA_W-1:0]      alpha
);

	logic signed [9:0] sd_c;
	logic signed [N_W-1:0] prod_c;
	logic signed [N_W-1:0] bias_c;
	logic signed [N_W-1:0] n_c;
	logic [16:0] nr_c;
	logic [KIND_W-1:0] kind_c;
	logic [ALPHA_W-1:0] alpha_c;

	logic v4_s4, v5_s5;
	logic rdy4, rdy5;
	logic signed [N_W-1:0] n_s4;
	logic [KIND_W-1:0] kind_s5;
	logic [ALPHA_W-1:0] alpha_s5;

	assign rdy5 = !v5_s5 || out_ready;
	assign rdy4 = !v4_s4 || rdy5;
	assign in_ready = rdy4;

	always_comb begin
		sd_c = $signed({1'b0, distance, 1'b0}) - 10'sd255;
		prod_c = N_W'(sd_c * $signed({1'b0, scale}));
		bias_c = (N_W'($signed(bias)) <<< 9) - (N_W'($signed(bias)) <<< 1);
		n_c = prod_c + COVER_HALF_N + bias_c;
	end

	always_comb begin
		nr_c = n_s4[16:0] + 17'd256;
		if (n_s4 <= 0) begin
			kind_c  = KIND_LEAVE;
			alpha_c = 8'd0;
		end else if (n_s4 >= COVER_FULL_N) begin
			kind_c  = KIND_FULL;
			alpha_c = 8'd255;
		end else begin
			kind_c  = KIND_BLEND;
			alpha_c = nr_c[16:9];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
		end else begin
			if (rdy4) v4_s4 <= in_valid;
			if (rdy5) v5_s5 <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) n_s4 <= n_c;
		if (rdy5) begin
			kind_s5  <= kind_c;
			alpha_s5 <= alpha_c;
		end
	end

	assign out_valid = v5_s5;
	assign kind = kind_s5;
	assign alpha = alpha_s5;

	`SDF_ASSERT(a_leave_zero, !v5_s5 || kind_s5 != KIND_LEAVE || alpha_s5 == 8'd0, "leave with alpha")
	`SDF_ASSERT(a_full_max, !v5_s5 || kind_s5 != KIND_FULL || alpha_s5 == 8'd255, "full not opaque")
	`SDF_ASSERT_NEXT(a_s4_hold, v4_s4 && !rdy5, v4_s4 && $stable(n_s4), "stage 4 lost on stall")

endmodule

`default_nettype wire

// File: rtl/sdf_texel_coverage_core.sv
`default_nettype none

// Coverage of one pixel of distance-field text. Each s_ word carries four 8-bit
// distance texels and an 8-bit x and y sample fraction; the core mixes them
// bilinearly, rounds to a distance 0..255 and maps it through distance_scale
// (unsigned Q8.8) and weight_bias (signed Q2.8) to a kind on m_tuser (leave,
// full, blend) and an alpha on m_tdata. One word per clock enters and leaves
// while m_tready is high, through five register stages (two lerp rows, column lerp,
// round and clamp, scale multiply, classify). Registers are written through
// the cfg_ port, which is always ready, and are meant to change only when idle.

module sdf_texel_coverage_core
	import sdf_tc_pkg::*;
#(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// texel_top_left, texel_top_right, texel_bottom_left, texel_bottom_right,
	// frac_x, frac_y; 8 bits each from bit 0 up
	input  wire logic [47:0]           s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// alpha
	output logic [ALPHA_W-1:0]         m_tdata,
	// coverage_kind
	output logic [KIND_W-1:0]          m_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SCALE_W-1:0] scale_q;
	logic [BIAS_W-1:0] bias_q;
	logic mid_valid;
	logic mid_ready;
	logic [TEXEL_W-1:0] mid_dist;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			bias_q  <= BIAS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DISTANCE_SCALE: scale_q <= cfg_data;
				REG_WEIGHT_BIAS:    bias_q  <= cfg_data[BIAS_W-1:0];
				default: ;
			endcase
		end
	end

	sdf_tc_bilerp #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_bilerp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.tl       (s_tdata[7:0]),
		.tr       (s_tdata[15:8]),
		.bl       (s_tdata[23:16]),
		.br       (s_tdata[31:24]),
		.fx_raw   (s_tdata[39:32]),
		.fy_raw   (s_tdata[47:40]),
		.out_valid(mid_valid),
		.out_ready(mid_ready),
		.distance (mid_dist)
	);

	sdf_tc_cover_map u_cover_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.scale    (scale_q),
		.bias     (bias_q),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.distance (mid_dist),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.kind     (m_tuser),
		.alpha    (m_tdata)
	);

endmodule

`default_nettype wire
